>>> rtl/query_block_sdnv_parser_top_assert.svh
// assertion macros for the query block parser
`ifndef QUERY_BLOCK_SDNV_PARSER_TOP_ASSERT_SVH
`define QUERY_BLOCK_SDNV_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define QBSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qbsp_pkg.sv
// ----------------------------------------------------------------------------
// qbsp_pkg
// Shared types and codes of the query block sdnv parser.
// ----------------------------------------------------------------------------
package qbsp_pkg;

  localparam int MAX_NUMBER_BYTES_DEF = 10;
  localparam int LENGTH_BITS_DEF      = 32;
  localparam int CNT_W                = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field codes
  localparam logic [3:0] FC_KIND     = 4'd0;
  localparam logic [3:0] FC_RULE     = 4'd1;
  localparam logic [3:0] FC_SECS     = 4'd2;
  localparam logic [3:0] FC_SEQ      = 4'd3;
  localparam logic [3:0] FC_IDLEN    = 4'd4;
  localparam logic [3:0] FC_IDBYTE   = 4'd5;
  localparam logic [3:0] FC_QLEN     = 4'd6;
  localparam logic [3:0] FC_QBYTE    = 4'd7;
  localparam logic [3:0] FC_FCOUNT   = 4'd8;
  localparam logic [3:0] FC_FOFF     = 4'd9;
  localparam logic [3:0] FC_FLEN     = 4'd10;
  localparam logic [3:0] FC_STATUS   = 4'd11;

  // block status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_BAD_KIND = 3'd3;
  localparam logic [2:0] ST_BAD_RULE = 3'd4;
  localparam logic [2:0] ST_TRAILING = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_block;
  } in_t;

  typedef struct packed {
    logic [3:0]  field_code;
    logic [63:0] field_value;
    logic [2:0]  status;
    logic        last;
  } out_t;

  // up to two results per parsed word, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } push_t;

endpackage

>>> rtl/query_block_sdnv_parser_top.sv
// ----------------------------------------------------------------------------
// query_block_sdnv_parser_top: byte-wide query extension block parser
// a byte is held in the input word register, its results then in the queue
// throughput one byte per cycle; an end word with a field gives two results,
// and a run of such words, or result_stall, stalls bytes while the queue drains
// sync reset clears parse state, result queue and strict_checks (no sweep)
// ----------------------------------------------------------------------------
module query_block_sdnv_parser_top #(
  parameter int MAX_NUMBER_BYTES = qbsp_pkg::MAX_NUMBER_BYTES_DEF,
  parameter int LENGTH_BITS      = qbsp_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  qbsp_pkg::in_t   byte_data,
  output logic            result_valid,
  input  logic            result_stall,
  output qbsp_pkg::out_t  result_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data
);

  `include "query_block_sdnv_parser_top_assert.svh"

  logic                        strict;
  logic                        hold_valid;
  qbsp_pkg::in_t               hold_data;
  logic                        fire;
  logic                        room;
  logic                        accept;
  logic                        pop;
  qbsp_pkg::push_t             push;
  logic [qbsp_pkg::QCNT_W-1:0] level;

  assign cfg_ready  = 1'b1;
  assign fire       = hold_valid & room;
  assign byte_stall = hold_valid & ~room;
  assign accept     = byte_valid & ~byte_stall;
  assign pop        = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      strict <= cfg_data;
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept | (hold_valid & ~fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_data <= byte_data;
    end
  end

  qbsp_decode #(
    .MAX_NUMBER_BYTES (MAX_NUMBER_BYTES),
    .LENGTH_BITS      (LENGTH_BITS)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (hold_data),
    .strict  (strict),
    .push    (push)
  );

  qbsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (result_data),
    .not_empty (result_valid),
    .room      (room),
    .level     (level)
  );

  `QBSP_ASSERT_IMP(a_push_fits, clk, rst, push.cnt != 2'd0,
    level <= qbsp_pkg::QCNT_W'(qbsp_pkg::QUEUE_DEPTH - 2), "result queue overrun")
  `QBSP_ASSERT_IMP(a_end_gives_status, clk, rst, fire && hold_data.end_of_block,
    push.cnt != 2'd0, "end word gave no status")
  `QBSP_ASSERT_NEXT(a_hold_kept, clk, rst, hold_valid && !fire,
    hold_valid && $stable(hold_data), "held word lost or changed")
  `QBSP_ASSERT_IMP(a_last_is_status, clk, rst, result_valid && result_data.last,
    result_data.field_code == qbsp_pkg::FC_STATUS, "last on a field result")

endmodule

>>> rtl/qbsp_decode.sv
// ----------------------------------------------------------------------------
// qbsp_decode
// Parse state and the per-word decode of the block layout.
// ----------------------------------------------------------------------------
module qbsp_decode #(
  parameter int MAX_NUMBER_BYTES = qbsp_pkg::MAX_NUMBER_BYTES_DEF,
  parameter int LENGTH_BITS      = qbsp_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  qbsp_pkg::in_t    byte_in,
  input  logic             strict,
  output qbsp_pkg::push_t  push
);

  localparam logic [63:0] LEN_LIM =
    (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [63:0] LEN_LIM_SHR = LEN_LIM >> 7;
  localparam logic [63:0] TS_LIM_SHR  = {64{1'b1}} >> 7;

  typedef enum logic [12:0] {
    PH_KIND    = 13'h0001,
    PH_RULE    = 13'h0002,
    PH_SECS    = 13'h0004,
    PH_SEQ     = 13'h0008,
    PH_IDLEN   = 13'h0010,
    PH_IDBYTES = 13'h0020,
    PH_QLEN    = 13'h0040,
    PH_QBYTES  = 13'h0080,
    PH_FCOUNT  = 13'h0100,
    PH_FOFF    = 13'h0200,
    PH_FLEN    = 13'h0400,
    PH_DONE    = 13'h0800,
    PH_SKIP    = 13'h1000
  } phase_t;

  phase_t                  phase, phase_next;
  logic [63:0]             acc, acc_next;
  logic [qbsp_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [LENGTH_BITS-1:0]  pay, pay_next;
  logic [LENGTH_BITS-1:0]  frag, frag_next;
  logic [2:0]              err, err_next;

  logic                    has_field;
  logic [3:0]              f_code;
  logic [63:0]             f_val;
  logic [2:0]              st;
  logic [7:0]              b;
  logic [63:0]             acc_sh;
  logic [qbsp_pkg::CNT_W-1:0] cnt_inc;
  logic [63:0]             lim_shr;
  qbsp_pkg::out_t          field_res, status_res;

  assign b       = byte_in.data_byte;
  assign acc_sh  = {acc[56:0], b[6:0]};
  assign cnt_inc = cnt + qbsp_pkg::CNT_W'(1);
  assign lim_shr = (phase == PH_SECS || phase == PH_SEQ) ? TS_LIM_SHR : LEN_LIM_SHR;

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    cnt_next   = cnt;
    pay_next   = pay;
    frag_next  = frag;
    err_next   = err;
    has_field  = 1'b0;
    f_code     = qbsp_pkg::FC_KIND;
    f_val      = 64'd0;
    st         = qbsp_pkg::ST_OK;

    unique case (phase)
      PH_KIND: begin
        if (strict && b > 8'd3) begin
          err_next   = qbsp_pkg::ST_BAD_KIND;
          phase_next = PH_SKIP;
        end else begin
          has_field  = 1'b1;
          f_code     = qbsp_pkg::FC_KIND;
          f_val      = {56'd0, b};
          phase_next = PH_RULE;
        end
      end
      PH_RULE: begin
        if (strict && b != 8'd0) begin
          err_next   = qbsp_pkg::ST_BAD_RULE;
          phase_next = PH_SKIP;
        end else begin
          has_field  = 1'b1;
          f_code     = qbsp_pkg::FC_RULE;
          f_val      = {56'd0, b};
          phase_next = PH_SECS;
        end
      end
      PH_SECS, PH_SEQ, PH_IDLEN, PH_QLEN, PH_FCOUNT, PH_FOFF, PH_FLEN: begin
        if (acc > lim_shr) begin
          acc_next   = 64'd0;
          cnt_next   = '0;
          err_next   = qbsp_pkg::ST_OVERFLOW;
          phase_next = PH_SKIP;
        end else if (b[7]) begin
          if (cnt_inc >= qbsp_pkg::CNT_W'(MAX_NUMBER_BYTES)) begin
            acc_next   = 64'd0;
            cnt_next   = '0;
            err_next   = qbsp_pkg::ST_OVERFLOW;
            phase_next = PH_SKIP;
          end else begin
            acc_next = acc_sh;
            cnt_next = cnt_inc;
          end
        end else begin
          // number complete
          acc_next  = 64'd0;
          cnt_next  = '0;
          has_field = 1'b1;
          f_val     = acc_sh;
          unique case (phase)
            PH_SECS: begin
              f_code     = qbsp_pkg::FC_SECS;
              phase_next = PH_SEQ;
            end
            PH_SEQ: begin
              f_code     = qbsp_pkg::FC_SEQ;
              phase_next = PH_IDLEN;
            end
            PH_IDLEN: begin
              f_code     = qbsp_pkg::FC_IDLEN;
              pay_next   = acc_sh[LENGTH_BITS-1:0];
              phase_next = (acc_sh != 64'd0) ? PH_IDBYTES : PH_QLEN;
            end
            PH_QLEN: begin
              f_code     = qbsp_pkg::FC_QLEN;
              pay_next   = acc_sh[LENGTH_BITS-1:0];
              phase_next = (acc_sh != 64'd0) ? PH_QBYTES : PH_FCOUNT;
            end
            PH_FCOUNT: begin
              f_code     = qbsp_pkg::FC_FCOUNT;
              frag_next  = acc_sh[LENGTH_BITS-1:0];
              phase_next = (acc_sh != 64'd0) ? PH_FOFF : PH_DONE;
            end
            PH_FOFF: begin
              f_code     = qbsp_pkg::FC_FOFF;
              phase_next = PH_FLEN;
            end
            default: begin
              f_code     = qbsp_pkg::FC_FLEN;
              frag_next  = frag - LENGTH_BITS'(1);
              phase_next = (frag != LENGTH_BITS'(1)) ? PH_FOFF : PH_DONE;
            end
          endcase
        end
      end
      PH_IDBYTES, PH_QBYTES: begin
        has_field = 1'b1;
        f_code    = (phase == PH_IDBYTES) ? qbsp_pkg::FC_IDBYTE : qbsp_pkg::FC_QBYTE;
        f_val     = {56'd0, b};
        pay_next  = pay - LENGTH_BITS'(1);
        if (pay == LENGTH_BITS'(1)) begin
          phase_next = (phase == PH_IDBYTES) ? PH_QLEN : PH_FCOUNT;
        end
      end
      PH_DONE: begin
        if (strict) begin
          err_next   = qbsp_pkg::ST_TRAILING;
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    // closing status, error wins over truncation
    if (err_next != qbsp_pkg::ST_OK) begin
      st = err_next;
    end else if (phase_next != PH_DONE) begin
      st = qbsp_pkg::ST_TRUNC;
    end

    if (byte_in.end_of_block) begin
      phase_next = PH_KIND;
      acc_next   = 64'd0;
      cnt_next   = '0;
      pay_next   = '0;
      frag_next  = '0;
      err_next   = qbsp_pkg::ST_OK;
    end
  end

  always_comb begin
    field_res.field_code  = f_code;
    field_res.field_value = f_val;
    field_res.status      = qbsp_pkg::ST_OK;
    field_res.last        = 1'b0;

    status_res.field_code  = qbsp_pkg::FC_STATUS;
    status_res.field_value = 64'd0;
    status_res.status      = st;
    status_res.last        = 1'b1;

    push.r1 = status_res;
    if (has_field) begin
      push.r0 = field_res;
    end else begin
      push.r0 = status_res;
    end
    if (!fire) begin
      push.cnt = 2'd0;
    end else begin
      push.cnt = {1'b0, has_field} + {1'b0, byte_in.end_of_block};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_KIND;
      acc   <= 64'd0;
      cnt   <= '0;
      pay   <= '0;
      frag  <= '0;
      err   <= qbsp_pkg::ST_OK;
    end else if (fire) begin
      phase <= phase_next;
      acc   <= acc_next;
      cnt   <= cnt_next;
      pay   <= pay_next;
      frag  <= frag_next;
      err   <= err_next;
    end
  end

endmodule

>>> rtl/qbsp_queue.sv
// ----------------------------------------------------------------------------
// qbsp_queue
// Small result queue, takes up to two results and gives one per cycle while pop is high.
// ----------------------------------------------------------------------------
module qbsp_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  qbsp_pkg::push_t             push,
  input  logic                        pop,
  output qbsp_pkg::out_t              head,
  output logic                        not_empty,
  output logic                        room,
  output logic [qbsp_pkg::QCNT_W-1:0] level
);

  qbsp_pkg::out_t                  mem [qbsp_pkg::QUEUE_DEPTH];
  logic [qbsp_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [qbsp_pkg::QCNT_W-1:0]     count;
  logic [qbsp_pkg::QPTR_W-1:0]     wr_ptr1;

  assign wr_ptr1   = wr_ptr + qbsp_pkg::QPTR_W'(1);
  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  // room for two results
  assign room      = (count <= qbsp_pkg::QCNT_W'(qbsp_pkg::QUEUE_DEPTH - 2));
  assign level     = count;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + qbsp_pkg::QPTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + qbsp_pkg::QPTR_W'(1);
      end
      count <= count + qbsp_pkg::QCNT_W'(push.cnt) - qbsp_pkg::QCNT_W'(pop);
    end
  end

endmodule

>>> test/tb_query_block_sdnv_parser_top.sv
// ----------------------------------------------------------------------------
// tb_query_block_sdnv_parser_top
// Feeds query extension blocks into the parser one byte per word and checks
// every tagged field and block status against a local decoder. Short fixed
// blocks come first, then random blocks (mostly well formed, some truncated,
// corrupted, padded or overflowing) under lax and strict checking, with
// random gaps on the byte side and random stalls on the result side, but for the last run.
// ----------------------------------------------------------------------------
module tb_query_block_sdnv_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int SETTLE_CYCLES   = 4;

  // decoder position inside a block; numeric and payload positions share
  // their value with the field code they produce
  typedef enum logic [3:0] {
    AT_KIND    = 4'd0,
    AT_RULE    = 4'd1,
    AT_SECS    = 4'd2,
    AT_SEQ     = 4'd3,
    AT_IDLEN   = 4'd4,
    AT_IDBYTES = 4'd5,
    AT_QLEN    = 4'd6,
    AT_QBYTES  = 4'd7,
    AT_FCOUNT  = 4'd8,
    AT_FOFF    = 4'd9,
    AT_FLEN    = 4'd10,
    AT_DONE    = 4'd11,
    AT_SKIP    = 4'd12
  } block_pos_e;

  logic           clk          = 1'b0;
  logic           rst          = 1'b1;
  logic           byte_valid   = 1'b0;
  logic           byte_stall;
  qbsp_pkg::in_t  byte_data    = '0;
  logic           result_valid;
  logic           result_stall = 1'b0;
  qbsp_pkg::out_t result_data;
  logic           cfg_valid    = 1'b0;
  logic           cfg_ready;
  logic           cfg_data     = 1'b0;

  // local decoder state
  logic        strict_q   = 1'b0;
  block_pos_e  at         = AT_KIND;
  logic [63:0] num_acc    = '0;
  int          num_len    = 0;
  logic [31:0] bytes_left = '0;
  logic [31:0] frags_left = '0;
  logic [2:0]  err_code   = qbsp_pkg::ST_OK;

  qbsp_pkg::out_t expected_fields[$];
  logic [7:0] block_bytes[$];

  bit   idling      = 1'b1;
  int   gap_pct     = 20;
  bit   quiet_spell = 1'b0;
  int   stall_left  = 0;
  int   errors      = 0;
  int   results_seen = 0;
  int   bytes_counted = 0;
  int   bytes_sent  = 0;
  int   blocks_sent = 0;
  int   status_tally[6] = '{default: 0};
  int   quiet_cycles = 0;
  qbsp_pkg::out_t want;

  query_block_sdnv_parser_top DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void expect_field(input logic [3:0] code, input logic [63:0] value,
                                       input logic [2:0] st, input logic closing);
    qbsp_pkg::out_t r;
    r.field_code  = code;
    r.field_value = value;
    r.status      = st;
    r.last        = closing;
    expected_fields.push_back(r);
  endfunction

  function automatic void fail_block(input logic [2:0] code);
    err_code = code;
    at       = AT_SKIP;
  endfunction

  // advance the local decoder by one accepted byte word
  function automatic void decode_byte(input qbsp_pkg::in_t item);
    logic [7:0]  b;
    logic [63:0] cap;
    logic [63:0] num;
    logic [3:0]  code;
    logic [2:0]  st;
    bit          over;
    bit          done;
    b    = item.data_byte;
    over = 1'b0;
    done = 1'b0;
    num  = '0;
    code = at;
    case (at)
      AT_KIND: begin
        if (strict_q && b > 8'd3) begin
          fail_block(qbsp_pkg::ST_BAD_KIND);
        end else begin
          expect_field(qbsp_pkg::FC_KIND, 64'(b), qbsp_pkg::ST_OK, 1'b0);
          at = AT_RULE;
        end
      end
      AT_RULE: begin
        if (strict_q && b != 8'd0) begin
          fail_block(qbsp_pkg::ST_BAD_RULE);
        end else begin
          expect_field(qbsp_pkg::FC_RULE, 64'(b), qbsp_pkg::ST_OK, 1'b0);
          at = AT_SECS;
        end
      end
      AT_SECS, AT_SEQ, AT_IDLEN, AT_QLEN, AT_FCOUNT, AT_FOFF, AT_FLEN: begin
        if (at == AT_SECS || at == AT_SEQ) cap = '1;
        else cap = (64'd1 << qbsp_pkg::LENGTH_BITS_DEF) - 64'd1;
        if (num_acc > (cap >> 7)) begin
          over = 1'b1;
        end else begin
          num_acc = (num_acc << 7) | 64'(b[6:0]);
          num_len++;
          if (!b[7]) done = 1'b1;
          else if (num_len >= qbsp_pkg::MAX_NUMBER_BYTES_DEF) over = 1'b1;
        end
        if (over || done) begin
          num     = num_acc;
          num_acc = '0;
          num_len = 0;
        end
        if (over) begin
          fail_block(qbsp_pkg::ST_OVERFLOW);
        end else if (done) begin
          expect_field(code, num, qbsp_pkg::ST_OK, 1'b0);
          case (at)
            AT_SECS: at = AT_SEQ;
            AT_SEQ:  at = AT_IDLEN;
            AT_IDLEN: begin
              bytes_left = num[31:0];
              if (num != 0) at = AT_IDBYTES;
              else at = AT_QLEN;
            end
            AT_QLEN: begin
              bytes_left = num[31:0];
              if (num != 0) at = AT_QBYTES;
              else at = AT_FCOUNT;
            end
            AT_FCOUNT: begin
              frags_left = num[31:0];
              if (num != 0) at = AT_FOFF;
              else at = AT_DONE;
            end
            AT_FOFF: at = AT_FLEN;
            default: begin
              frags_left--;
              if (frags_left != 0) at = AT_FOFF;
              else at = AT_DONE;
            end
          endcase
        end
      end
      AT_IDBYTES, AT_QBYTES: begin
        expect_field(code, 64'(b), qbsp_pkg::ST_OK, 1'b0);
        bytes_left--;
        if (bytes_left == 0) begin
          if (at == AT_IDBYTES) at = AT_QLEN;
          else at = AT_FCOUNT;
        end
      end
      AT_DONE: begin
        if (strict_q) fail_block(qbsp_pkg::ST_TRAILING);
      end
      default: ;
    endcase
    if (item.end_of_block) begin
      st = err_code;
      if (st == qbsp_pkg::ST_OK && at != AT_DONE) st = qbsp_pkg::ST_TRUNC;
      expect_field(qbsp_pkg::FC_STATUS, '0, st, 1'b1);
      at         = AT_KIND;
      num_acc    = '0;
      num_len    = 0;
      bytes_left = '0;
      frags_left = '0;
      err_code   = qbsp_pkg::ST_OK;
    end
  endfunction

  // one byte word, with an occasional gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic eob);
    qbsp_pkg::in_t item;
    item.data_byte    = b;
    item.end_of_block = eob;
    if (idling && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= item;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    // trailing bytes in lax mode and bytes after an error are just dropped
    if (!(at == AT_SKIP || (at == AT_DONE && !strict_q))) bytes_counted++;
    decode_byte(item);
  endtask

  task automatic send_block();
    blocks_sent++;
    foreach (block_bytes[i]) send_byte(block_bytes[i], i == block_bytes.size() - 1);
  endtask

  task automatic settle();
    byte_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_strict_checks(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    strict_q = value;
  endtask

  // sdnv with an occasional run of leading zero groups
  function automatic void push_sdnv(input logic [69:0] v);
    int groups;
    int pad;
    groups = 1;
    while (groups < 10 && (v >> (7 * groups)) != 0) groups++;
    pad = ($urandom_range(0, 47) == 0) ? $urandom_range(1, 9) : 0;
    repeat (pad) block_bytes.push_back(8'h80);
    for (int i = groups - 1; i >= 0; i--) block_bytes.push_back({i != 0, v[7 * i +: 7]});
  endfunction

  function automatic logic [69:0] pick_number(input int bits);
    logic [69:0] full;
    logic [69:0] r;
    int          sel;
    full = (70'd1 << bits) - 70'd1;
    r    = {6'($urandom), 32'($urandom), 32'($urandom)} & full;
    sel  = $urandom_range(0, 47);
    if (sel == 0) return '0;
    if (sel < 3) return full;
    // just past the limit
    if (sel == 3) return full + 70'd1 + 70'(r[7:0]);
    if (sel < 16) return 70'($urandom_range(0, 127));
    if (sel < 28) return r & 70'h3FFF;
    return r;
  endfunction

  task automatic make_block();
    logic [69:0] len;
    int          cut;
    block_bytes.delete();
    if (strict_q && $urandom_range(0, 9) != 0) block_bytes.push_back(8'($urandom_range(0, 3)));
    else block_bytes.push_back(8'($urandom));
    if ($urandom_range(0, strict_q ? 9 : 2) == 0) block_bytes.push_back(8'($urandom));
    else block_bytes.push_back(8'h00);
    push_sdnv(pick_number(64));
    push_sdnv(pick_number(64));
    for (int part = 0; part < 2; part++) begin
      if ($urandom_range(0, 24) == 0) len = pick_number(qbsp_pkg::LENGTH_BITS_DEF);
      else len = 70'($urandom_range(0, 6));
      push_sdnv(len);
      // a huge length cannot be completed, so the block is cut short here
      if (len > 12) begin
        repeat (12) block_bytes.push_back(8'($urandom));
        return;
      end
      repeat (int'(len)) block_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 24) == 0) len = pick_number(qbsp_pkg::LENGTH_BITS_DEF);
    else len = 70'($urandom_range(0, 4));
    push_sdnv(len);
    repeat ((len > 6) ? 6 : int'(len)) begin
      push_sdnv(pick_number(qbsp_pkg::LENGTH_BITS_DEF));
      push_sdnv(pick_number(qbsp_pkg::LENGTH_BITS_DEF));
    end
    if (len > 6) return;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) block_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, block_bytes.size());
      while (block_bytes.size() > cut) void'(block_bytes.pop_back());
    end
    if ($urandom_range(0, 9) == 0) begin
      block_bytes[$urandom_range(0, block_bytes.size() - 1)] = 8'($urandom);
    end
  endtask

  task automatic test_lax_directed();
    gap_pct = 20;
    // kind and rule at their top value, then cut short
    block_bytes = '{8'hFF, 8'hFF};
    send_block();
    // smallest complete block, empty payloads, one ignored trailing byte
    block_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55};
    send_block();
  endtask

  task automatic test_strict_directed();
    settle();
    write_strict_checks(1'b1);
    block_bytes = '{8'h04, 8'h00};
    send_block();
    block_bytes = '{8'h03, 8'h01};
    send_block();
    // id length one past 32 bits, remaining byte swallowed
    block_bytes = '{8'h03, 8'h00, 8'h00, 8'h00, 8'h90, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00};
    send_block();
  endtask

  task automatic test_random_blocks(input logic strict_on, input int target, input bit with_idle);
    int start;
    settle();
    write_strict_checks(strict_on);
    idling = with_idle;
    start  = bytes_sent;
    while (bytes_sent - start < target) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if ($urandom_range(0, 19) == 0) begin
        block_bytes.delete();
        repeat ($urandom_range(1, 10)) block_bytes.push_back(8'($urandom));
      end else begin
        make_block();
      end
      send_block();
    end
  endtask

  // result side stalls in bursts, with quiet spells in between
  always @(posedge clk) begin
    if (rst || !idling) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (!quiet_spell && $urandom_range(0, 4) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      result_stall <= 1'b0;
    end
    if ($urandom_range(0, 63) == 0) quiet_spell <= ~quiet_spell;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (result_data.field_code == qbsp_pkg::FC_STATUS && result_data.status < 3'd6)
        status_tally[result_data.status]++;
      if (expected_fields.size() == 0) begin
        errors++;
        $display("%0t: unexpected result code %0d value %h status %0d last %0b", $time,
                 result_data.field_code, result_data.field_value, result_data.status,
                 result_data.last);
      end else begin
        want = expected_fields.pop_front();
        if (result_data.field_code !== want.field_code ||
            result_data.field_value !== want.field_value ||
            result_data.status !== want.status || result_data.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected code %0d value %h status %0d last %0b", $time,
                   want.field_code, want.field_value, want.status, want.last);
          $display("%0t:          actual   code %0d value %h status %0d last %0b", $time,
                   result_data.field_code, result_data.field_value, result_data.status,
                   result_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_CYCLES, expected_fields.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lax_directed();
    test_strict_directed();
    test_random_blocks(1'b1, 190, 1'b1);
    test_random_blocks(1'b0, 200, 1'b1);
    test_random_blocks(1'b1, 130, 1'b0);
    settle();
    $display("covered %0d blocks, %0d bytes (%0d parsed), %0d results, lax and strict",
             blocks_sent, bytes_sent, bytes_counted, results_seen);
    $display("block status ok %0d trunc %0d overflow %0d kind %0d rule %0d trailing %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
